[src/unsigned_divide_64_core_assert.svh]
// Assertion macros for the checker file.
`ifndef UNSIGNED_DIVIDE_64_CORE_ASSERT_SVH
`define UNSIGNED_DIVIDE_64_CORE_ASSERT_SVH

// Check on every clock edge outside reset.
`define UD64_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define UD64_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/udiv64_pkg.sv]
`timescale 1ns / 1ps

package udiv64_pkg;

  parameter int DATA_W            = 64;
  parameter int OPERAND_WIDTH_DEF = 64;
  parameter int TDATA_W           = 2 * DATA_W;
  parameter int TUSER_W           = 1;

endpackage

[src/unsigned_divide_64_core.sv]
`timescale 1ns / 1ps
// channel   | ports               | payload
// ----------+---------------------+------------------------------------------
// input     | in_tvalid/in_tready | in_tdata: dividend, divisor
// result    | out_tvalid/tready   | out_tdata: quotient, remainder;
//           |                     | out_tuser: divide_by_zero
//
// One transaction per cycle unless the result side stalls; the pipeline is
// one radix-2 subtract stage per quotient bit plus the output register.
// Reset clears the valid bit of every stage and of the output register.
// A stall at the result side freezes the whole pipeline; nothing is dropped.

module unsigned_divide_64_core
  import udiv64_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // dividend[63:0], divisor[127:64]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // quotient[63:0], remainder[127:64]
  output logic [TUSER_W-1:0] out_tuser   // divide_by_zero[0]
);

  localparam int W = OPERAND_WIDTH;

  logic         adv;
  logic         valid_a [0:W];
  logic         dz_a    [0:W];
  logic [W-1:0] rem_a   [0:W];
  logic [W-1:0] quo_a   [0:W];
  logic [W-1:0] den_a   [0:W];

  logic               out_valid_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic [TDATA_W-1:0] out_tdata_nxt;
  logic [TUSER_W-1:0] out_tuser_r;
  logic [W-1:0]       quo_fin;
  logic [W-1:0]       rem_fin;

  // advance whenever the output register is free or being drained
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign valid_a[0] = in_tvalid;
  assign rem_a[0]   = '0;
  assign quo_a[0]   = in_tdata[W-1:0];
  assign den_a[0]   = in_tdata[DATA_W+W-1:DATA_W];
  assign dz_a[0]    = (in_tdata[DATA_W+W-1:DATA_W] == '0);

  for (genvar k = 0; k < W; k++) begin : g_stage
    udiv64_stage #(
      .W(W)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (valid_a[k]),
      .dz_i    (dz_a[k]),
      .rem_i   (rem_a[k]),
      .quo_i   (quo_a[k]),
      .den_i   (den_a[k]),
      .valid_o (valid_a[k+1]),
      .dz_o    (dz_a[k+1]),
      .rem_o   (rem_a[k+1]),
      .quo_o   (quo_a[k+1]),
      .den_o   (den_a[k+1])
    );
  end

  // force all ones on a zero divisor
  always_comb begin
    quo_fin       = dz_a[W] ? '1 : quo_a[W];
    rem_fin       = dz_a[W] ? '1 : rem_a[W];
    out_tdata_nxt = {DATA_W'(rem_fin), DATA_W'(quo_fin)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_a[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= TUSER_W'(dz_a[W]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[src/udiv64_stage.sv]
`timescale 1ns / 1ps

module udiv64_stage #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         valid_i,
  input  logic         dz_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] den_i,
  output logic         valid_o,
  output logic         dz_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] den_o
);

  logic         valid_r;
  logic         dz_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] quo_r;
  logic [W-1:0] den_r;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_i, quo_i[W-1]};
    diff    = rem_sh - {1'b0, den_i};
    ge      = (rem_sh >= {1'b0, den_i});
    rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
    quo_nxt = {quo_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz_r  <= dz_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      den_r <= den_i;
    end
  end

  assign valid_o = valid_r;
  assign dz_o    = dz_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign den_o   = den_r;

endmodule

[src/udiv64_chk.sv]
`timescale 1ns / 1ps
`include "unsigned_divide_64_core_assert.svh"

module udiv64_chk
  import udiv64_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic [TUSER_W-1:0] out_tuser
);

  localparam logic [DATA_W-1:0] OP_MASK = {DATA_W{1'b1}} >> (DATA_W - OPERAND_WIDTH);

  logic                       in_fire;
  logic                       out_stall;
  logic [DATA_W-1:0]          out_quo;
  logic [DATA_W-1:0]          out_rem;
  logic                       out_ones;
  logic                       out_clean;
  logic [TDATA_W+TUSER_W-1:0] out_word;

  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_quo   = out_tdata[DATA_W-1:0];
  assign out_rem   = out_tdata[TDATA_W-1:DATA_W];
  assign out_ones  = (out_quo == OP_MASK) && (out_rem == OP_MASK);
  assign out_clean = ((out_quo & ~OP_MASK) == '0) && ((out_rem & ~OP_MASK) == '0);
  assign out_word  = {out_tuser, out_tdata};

  `UD64_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `UD64_ASSERT(a_stall_hold, out_stall |=> out_tvalid && $stable(out_word), "stalled result changed")
  `UD64_ASSERT(a_dz_ones, out_tvalid && out_tuser[0] |-> out_ones, "zero divisor not all ones")
  `UD64_ASSERT(a_upper_zero, out_tvalid |-> out_clean, "result bits above operand width set")
  `UD64_ASSERT(a_no_early, $past(!rst_n) && !in_fire |=> !out_tvalid, "result without transaction")

endmodule

bind unsigned_divide_64_core udiv64_chk #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_udiv64_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
